FILE: rtl/core/dcq_pkg.sv
// Shared types and constants for the duplicate-rejecting circular queue.
// Used by dcq_cell, dcq_cell_chain and dedup_circular_queue; depends on nothing.
`default_nettype none

package dcq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = 5;
   localparam int DATA_W = 32;

   // Request codes.
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_SEARCH = 2'd2;

   // Result status codes.
   localparam logic [2:0] STS_INSERTED  = 3'd0;
   localparam logic [2:0] STS_DUPLICATE = 3'd1;
   localparam logic [2:0] STS_FULL      = 3'd2;
   localparam logic [2:0] STS_REMOVED   = 3'd3;
   localparam logic [2:0] STS_EMPTY     = 3'd4;
   localparam logic [2:0] STS_FOUND     = 3'd5;
   localparam logic [2:0] STS_NOT_FOUND = 3'd6;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [IDX_W-1:0] slot;
   } tok_type;

   // Ring pointers and the capacity in use, broadcast to every cell so each can
   // tell if it is held.
   typedef struct packed {
      logic             empty;
      logic [IDX_W-1:0] head;
      logic [IDX_W-1:0] tail;
      logic [CNT_W-1:0] cap;
   } ring_type;

   // Entry write, broadcast to every cell.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  slot;
      logic [DATA_W-1:0] data;
   } wr_type;

endpackage

`default_nettype wire

FILE: rtl/core/dcq_cell.sv
// One ring slot: stores an entry and passes the search token to its neighbor.
// Depends on dcq_pkg.
`default_nettype none

module dcq_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [dcq_pkg::IDX_W-1:0]  slot_id,
   input  wire logic [dcq_pkg::DATA_W-1:0] key,
   input  wire dcq_pkg::ring_type        ring,
   input  wire dcq_pkg::wr_type          wr,
   input  wire dcq_pkg::tok_type         tok_up,
   output dcq_pkg::tok_type              tok_down
);

   logic [dcq_pkg::DATA_W-1:0] entry_ff;
   dcq_pkg::tok_type           tok_ff;
   dcq_pkg::tok_type           tok_in;
   logic                       held;

   // The slot is held when it lies between head and tail, with wrap. On a
   // wrapped ring only slots below the capacity in use count, since slots
   // beyond it may still hold entries from a larger ring.
   always_comb begin
      if (ring.empty) begin
         held = 1'b0;
      end else if (ring.head <= ring.tail) begin
         held = (slot_id >= ring.head) && (slot_id <= ring.tail);
      end else begin
         held = ((slot_id >= ring.head) && (dcq_pkg::CNT_W'(slot_id) < ring.cap))
                || (slot_id <= ring.tail);
      end
   end

   always_comb begin
      tok_in = tok_up;
      if (tok_up.valid && !tok_up.found && held && (entry_ff == key)) begin
         tok_in.found = 1'b1;
         tok_in.slot  = slot_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.slot == slot_id)) begin
         entry_ff <= wr.data;
      end
   end

   assign tok_down = tok_ff;

endmodule

`default_nettype wire

FILE: rtl/core/dcq_cell_chain.sv
// Row of DEPTH slot cells; the search token walks one cell per cycle.
// Depends on dcq_pkg and dcq_cell.
`default_nettype none

module dcq_cell_chain (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [dcq_pkg::DATA_W-1:0] key,
   input  wire dcq_pkg::ring_type        ring,
   input  wire dcq_pkg::wr_type          wr,
   input  wire dcq_pkg::tok_type         tok_first,
   output dcq_pkg::tok_type              tok_last
);

   dcq_pkg::tok_type tok_link [dcq_pkg::DEPTH+1];

   assign tok_link[0] = tok_first;

   for (genvar i = 0; i < dcq_pkg::DEPTH; i++) begin : g_cell
      dcq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .slot_id  (dcq_pkg::IDX_W'(i)),
         .key      (key),
         .ring     (ring),
         .wr       (wr),
         .tok_up   (tok_link[i]),
         .tok_down (tok_link[i+1])
      );
   end

   assign tok_last = tok_link[dcq_pkg::DEPTH];

endmodule

`default_nettype wire

FILE: rtl/core/dedup_circular_queue.sv
// Duplicate-rejecting circular queue of signed 32-bit values.
// A request is taken only while idle; its search token then walks the row of DEPTH slot
// cells, one cell per cycle, and the result is committed once the result register is
// free. No new request is taken until the last one has been committed.
// Reset (synchronous, active high): queue empty, head and tail at 0, capacity 16.
// Stored entries are not cleared; only held entries are ever compared.
`default_nettype none

module dedup_circular_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Request channel
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_type,
   input  wire logic signed [31:0]         req_value,
   // Result channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [2:0]                      rsp_status,
   output logic [dcq_pkg::IDX_W-1:0]       rsp_slot,
   output logic [dcq_pkg::CNT_W-1:0]       rsp_count,
   // Register port
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [2:0]                 csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int IDX_W = dcq_pkg::IDX_W;
   localparam int CNT_W = dcq_pkg::CNT_W;

   // The controller is idle until a request arrives, then waits for the search
   // token to leave the last cell, then commits the result once the result
   // register can take it.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_COMMIT
   } state_type;

   state_type        state_ff,     state_in;
   logic [1:0]       op_ff,        op_in;
   logic [31:0]      key_ff,       key_in;
   logic             launch_ff,    launch_in;
   logic             found_ff,     found_in;
   logic [IDX_W-1:0] hit_slot_ff,  hit_slot_in;
   logic [IDX_W-1:0] head_ff,      head_in;
   logic [IDX_W-1:0] tail_ff,      tail_in;
   logic             empty_ff,     empty_in;
   logic [CNT_W-1:0] capacity_ff,  capacity_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0] rsp_slot_ff,  rsp_slot_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   dcq_pkg::ring_type ring;
   dcq_pkg::wr_type   wr;
   dcq_pkg::tok_type  tok_first;
   dcq_pkg::tok_type  tok_last;

   logic             csr_wr;
   logic [CNT_W-1:0] wcap;
   logic [IDX_W-1:0] tail_next;
   logic [IDX_W-1:0] head_next;

   // Next slot around the ring of cap slots in use.
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] x,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] n;
      n = CNT_W'(x) + CNT_W'(1);
      return (n >= cap) ? '0 : n[IDX_W-1:0];
   endfunction

   // Number of entries held for the given pointers.
   function automatic logic [CNT_W-1:0] held_count(input logic             empty,
                                                   input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] tail,
                                                   input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] n;
      if (empty) begin
         n = '0;
      end else if (tail >= head) begin
         n = CNT_W'(tail) - CNT_W'(head) + CNT_W'(1);
      end else begin
         n = CNT_W'(tail) + cap - CNT_W'(head) + CNT_W'(1);
      end
      return n;
   endfunction

   // The search token enters the first cell in the cycle after acceptance and
   // picks up the slot of the held entry that matches the key. Held entries are
   // unique, since duplicates are never inserted.
   assign ring      = '{empty: empty_ff, head: head_ff, tail: tail_ff, cap: capacity_ff};
   assign tok_first = '{valid: launch_ff, found: 1'b0, slot: '0};

   dcq_cell_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .key       (key_ff),
      .ring      (ring),
      .wr        (wr),
      .tok_first (tok_first),
      .tok_last  (tok_last)
   );

   // A register write clamps the capacity into 1..DEPTH and empties the queue.
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0);

   always_comb begin
      wcap = csr_pwdata[CNT_W-1:0];
      if (wcap == '0) begin
         wcap = CNT_W'(1);
      end else if (wcap > CNT_W'(dcq_pkg::DEPTH)) begin
         wcap = CNT_W'(dcq_pkg::DEPTH);
      end
   end

   assign tail_next = ring_next(tail_ff, capacity_ff);
   assign head_next = ring_next(head_ff, capacity_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      launch_in     = 1'b0;
      found_in      = found_ff;
      hit_slot_in   = hit_slot_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      capacity_in   = capacity_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      wr            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_type;
               key_in    = req_value;
               launch_in = 1'b1;
               state_in  = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (tok_last.valid) begin
               found_in    = tok_last.found;
               hit_slot_in = tok_last.slot;
               state_in    = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // The result register takes a new transaction once the old one
            // has gone or is leaving in this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_slot_in = '0;
               case (op_ff)
                  dcq_pkg::REQ_INSERT: begin
                     if (empty_ff) begin
                        head_in       = '0;
                        tail_in       = '0;
                        empty_in      = 1'b0;
                        wr.en         = 1'b1;
                        wr.slot       = '0;
                        wr.data       = key_ff;
                        rsp_status_in = dcq_pkg::STS_INSERTED;
                     end else if (tail_next == head_ff) begin
                        rsp_status_in = dcq_pkg::STS_FULL;
                     end else if (found_ff) begin
                        rsp_status_in = dcq_pkg::STS_DUPLICATE;
                     end else begin
                        tail_in       = tail_next;
                        wr.en         = 1'b1;
                        wr.slot       = tail_next;
                        wr.data       = key_ff;
                        rsp_status_in = dcq_pkg::STS_INSERTED;
                     end
                  end
                  dcq_pkg::REQ_REMOVE: begin
                     if (empty_ff) begin
                        rsp_status_in = dcq_pkg::STS_EMPTY;
                     end else begin
                        // Taking the last entry returns both pointers to zero.
                        if (head_ff == tail_ff) begin
                           head_in  = '0;
                           tail_in  = '0;
                           empty_in = 1'b1;
                        end else begin
                           head_in = head_next;
                        end
                        rsp_status_in = dcq_pkg::STS_REMOVED;
                     end
                  end
                  dcq_pkg::REQ_SEARCH: begin
                     if (found_ff) begin
                        rsp_status_in = dcq_pkg::STS_FOUND;
                        rsp_slot_in   = hit_slot_ff;
                     end else begin
                        rsp_status_in = dcq_pkg::STS_NOT_FOUND;
                     end
                  end
                  default: begin
                     // The unused request code changes nothing.
                     rsp_status_in = dcq_pkg::STS_NOT_FOUND;
                  end
               endcase
               rsp_count_in = held_count(empty_in, head_in, tail_in, capacity_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The user must make register writes only while the block is idle; the block itself does not enforce it.
      if (csr_wr) begin
         capacity_in = wcap;
         head_in     = '0;
         tail_in     = '0;
         empty_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         capacity_ff  <= CNT_W'(dcq_pkg::DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      found_ff      <= found_in;
      hit_slot_ff   <= hit_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_count  = rsp_count_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {(32 - CNT_W)'(0), capacity_ff} : '0;

endmodule

`default_nettype wire

FILE: test/dcq_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the duplicate-rejecting circular queue. It tracks the ring from the
// request, result and register transactions, predicts every result and compares it.
// Depends on dcq_pkg for the depth, the field widths and the request and status codes.
module dcq_result_checker #(
   parameter logic [2:0] CAP_ADDR = '0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_ready,
   input  wire logic [1:0]              req_type,
   input  wire logic [31:0]             req_value,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire logic [2:0]              rsp_status,
   input  wire logic [dcq_pkg::IDX_W-1:0] rsp_slot,
   input  wire logic [dcq_pkg::CNT_W-1:0] rsp_count,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic                    csr_pready,
   input  wire logic [2:0]              csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output int                           error_count,
   output int                           pending_results,
   output int                           results_checked,
   output logic [6:0]                   statuses_seen
);
   import dcq_pkg::*;

   typedef struct packed {
      logic [2:0]       status;
      logic [IDX_W-1:0] slot;
      logic [CNT_W-1:0] count;
   } queue_outcome_t;

   logic [DATA_W-1:0] ring_data [DEPTH];
   int                head_pos;
   int                tail_pos;
   int                ring_size;
   bit                ring_empty;
   queue_outcome_t    awaited_outcomes [$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic void empty_ring();
      head_pos = 0;
      tail_pos = 0;
      ring_empty = 1'b1;
   endfunction

   // Next slot on the ring, wrapping at the capacity in use rather than the built depth.
   function automatic int next_slot(input int idx);
      return (idx + 1 >= ring_size) ? 0 : idx + 1;
   endfunction

   function automatic int held_entries();
      if (ring_empty) return 0;
      if (tail_pos >= head_pos) return 1 + tail_pos - head_pos;
      return 1 + tail_pos + ring_size - head_pos;
   endfunction

   // Walks the held entries from the head and gives the slot of the first match.
   function automatic bit locate_value(input logic [31:0] v, output int where);
      int pos;
      int n;
      pos = head_pos;
      n = held_entries();
      where = 0;
      for (int k = 0; k < n; k++) begin
         if (ring_data[pos % DEPTH] == v) begin
            where = pos;
            return 1'b1;
         end
         pos = next_slot(pos);
      end
      return 1'b0;
   endfunction

   function automatic queue_outcome_t apply_request(input logic [1:0] op, input logic [31:0] v);
      queue_outcome_t r;
      int where;
      int n;
      r = '0;
      r.status = STS_NOT_FOUND;
      case (op)
         REQ_INSERT: begin
            if (ring_empty) begin
               head_pos = 0;
               tail_pos = 0;
               ring_data[0] = v;
               ring_empty = 1'b0;
               r.status = STS_INSERTED;
            end else if (next_slot(tail_pos) == head_pos) begin
               r.status = STS_FULL;
            end else if (locate_value(v, where)) begin
               r.status = STS_DUPLICATE;
            end else begin
               tail_pos = next_slot(tail_pos);
               ring_data[tail_pos % DEPTH] = v;
               r.status = STS_INSERTED;
            end
         end
         REQ_REMOVE: begin
            n = held_entries();
            if (n == 0) begin
               r.status = STS_EMPTY;
            end else begin
               if (n == 1) empty_ring();
               else head_pos = next_slot(head_pos);
               r.status = STS_REMOVED;
            end
         end
         REQ_SEARCH: begin
            if (locate_value(v, where)) begin
               r.status = STS_FOUND;
               r.slot = IDX_W'(where);
            end
         end
         default: ;
      endcase
      r.count = CNT_W'(held_entries());
      return r;
   endfunction

   always @(posedge clock) begin
      queue_outcome_t want;
      logic [4:0] raw_cap;
      if (reset) begin
         ring_size = DEPTH;
         empty_ring();
         awaited_outcomes.delete();
         error_count = 0;
         pending_results = 0;
         results_checked = 0;
         statuses_seen = '0;
      end else begin
         // Results are checked before new requests are queued: a result can never
         // belong to a request accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (rsp_status <= STS_NOT_FOUND) statuses_seen[rsp_status] = 1'b1;
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("result with no request outstanding, status", rsp_status, -1);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_slot !== want.slot)
                  report_mismatch("slot", rsp_slot, want.slot);
               if (rsp_count !== want.count)
                  report_mismatch("count", rsp_count, want.count);
               results_checked++;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CAP_ADDR) begin
            raw_cap = csr_pwdata[4:0];
            if (raw_cap == 0) ring_size = 1;
            else if (raw_cap > DEPTH) ring_size = DEPTH;
            else ring_size = raw_cap;
            empty_ring();
         end
         if (req_valid && req_ready)
            awaited_outcomes.push_back(apply_request(req_type, req_value));
         pending_results = awaited_outcomes.size();
      end
   end

endmodule

FILE: test/tb_dedup_circular_queue.sv
`timescale 1ns / 1ps
// Top of the testbench for dedup_circular_queue: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Depends on dcq_pkg, the block and
// dcq_result_checker, which predicts and compares every result.
module tb_dedup_circular_queue;
   import dcq_pkg::*;

   // The capacity register is the only register, so it sits at byte address 0.
   localparam logic [2:0] CAP_ADDR = 3'd0;
   // Request code 3 is unused by the block; it must leave the ring alone.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int POOL_SIZE = 20;
   localparam int ITEMS_PER_PHASE = 68;
   localparam int PHASES = 7;
   localparam int LONG_HOLD_CYCLES = 400;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_type;
   logic signed [31:0]   req_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [2:0]           rsp_status;
   logic [IDX_W-1:0]     rsp_slot;
   logic [CNT_W-1:0]     rsp_count;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [2:0]           csr_paddr;
   logic [31:0]          csr_pwdata;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   int                   error_count;
   int                   pending_results;
   int                   results_checked;
   logic [6:0]           statuses_seen;
   int                   requests_sent = 0;

   // Random idling is switched off for the final phase; stall_phase asks the result
   // side for one long hold-off so that the block backs up into its request channel.
   bit                   quiet = 1'b0;
   bit                   stall_phase = 1'b0;

   // Values are mostly drawn from a small pool so that duplicates and search hits are
   // common. The pool opens with the extremes of the signed range.
   logic [31:0]          value_pool [POOL_SIZE];

   always #2 clock = ~clock;

   dedup_circular_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_slot    (rsp_slot),
      .rsp_count   (rsp_count),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dcq_result_checker #(
      .CAP_ADDR (CAP_ADDR)
   ) result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_count       (rsp_count),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .error_count     (error_count),
      .pending_results (pending_results),
      .results_checked (results_checked),
      .statuses_seen   (statuses_seen)
   );

   // Offers one request transaction and returns at the edge that accepts it. Valid is
   // left high so that back-to-back requests never lower and raise it in one step; it
   // only drops at the start of an idle burst or when the queue is drained.
   task automatic send_request(input logic [1:0] op, input logic [31:0] v);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= op;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Waits until every expected result has been returned. The count is sampled on the
   // falling edge, when the checker has finished with the rising one.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      @(posedge clock);
   endtask

   // A register write: a setup phase, then an access phase that completes on pready.
   task automatic write_capacity(input logic [31:0] cap);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= cap;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 6) == 0) return $urandom;
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Result side. Ready is mostly high, with random holds, and one long hold-off when
   // asked for, during which the sender keeps offering requests.
   initial begin : result_sink
      bit held_long;
      held_long = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_phase && !held_long) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            held_long = 1'b1;
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] phase_caps [PHASES];
      int          pick;
      logic [1:0]  op;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_type    <= REQ_INSERT;
      req_value   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= '0;

      value_pool[0] = 32'h7FFF_FFFF;
      value_pool[1] = 32'h8000_0000;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset capacity of 16. Underflow and a miss on an empty
      // queue come first, then the unused request code, then the signed extremes.
      send_request(REQ_REMOVE, 32'h0);
      send_request(REQ_SEARCH, 32'h0);
      send_request(REQ_UNUSED, 32'h7FFF_FFFF);
      send_request(REQ_INSERT, 32'h7FFF_FFFF);
      send_request(REQ_INSERT, 32'h8000_0000);
      send_request(REQ_INSERT, 32'h0000_0000);
      send_request(REQ_INSERT, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 32'h7FFF_FFFF);
      send_request(REQ_SEARCH, 32'h8000_0000);
      send_request(REQ_SEARCH, 32'h0001_2345);
      // Draining the queue sends head and tail back to slot 0; one more remove underflows.
      repeat (5) send_request(REQ_REMOVE, 32'h0);
      drain_results();

      // A two-slot ring: fill it, hit full, then wrap the tail round to slot 0 and find
      // the wrapped value there.
      write_capacity(32'd2);
      send_request(REQ_INSERT, 32'h0000_00A5);
      send_request(REQ_INSERT, 32'hDEAD_BEEF);
      send_request(REQ_INSERT, 32'h1234_5678);
      send_request(REQ_REMOVE, 32'h0);
      send_request(REQ_INSERT, 32'h1234_5678);
      send_request(REQ_SEARCH, 32'h1234_5678);
      send_request(REQ_SEARCH, 32'h0000_00A5);
      drain_results();

      // A capacity of zero is taken as one, so the second insert finds the ring full.
      write_capacity(32'd0);
      send_request(REQ_INSERT, 32'h5555_AAAA);
      send_request(REQ_INSERT, 32'hAAAA_5555);
      drain_results();

      // Random phases, each behind a capacity write that also empties the queue. The
      // list covers the largest ring, a value above the depth, a single slot, and a value
      // whose upper bits must be ignored. The sixth phase carries the long result stall
      // and the last one runs with no idling at all.
      phase_caps = '{32'd16, 32'd3, 32'd31, 32'd1, 32'hFFFF_FFE5, 32'd16, 32'd8};
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(phase_caps[p]);
         stall_phase = (p == PHASES - 2);
         quiet = (p == PHASES - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Inserts outweigh removes so the ring keeps reaching full.
            pick = $urandom_range(0, 99);
            if (pick < 45) op = REQ_INSERT;
            else if (pick < 70) op = REQ_REMOVE;
            else if (pick < 95) op = REQ_SEARCH;
            else op = REQ_UNUSED;
            send_request(op, pick_value());
         end
         drain_results();
      end

      // Let the block settle past its pipeline depth before the verdict.
      repeat (2 * DEPTH + 8) @(posedge clock);

      $display("Summary: %0d requests, %0d results checked, capacities from 1 to %0d,",
               requests_sent, results_checked, DEPTH);
      $display("  with wrap-around, full, duplicate and underflow traffic; status codes seen %b",
               statuses_seen);
      if (error_count == 0 && pending_results == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Hard limit, far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("Timeout with %0d results still outstanding", pending_results);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
